FILE: hw/rtl/lock_motor_bridge_controller_macros.svh
// Assertion macros shared by the lock motor bridge controller RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef LOCK_MOTOR_BRIDGE_CONTROLLER_MACROS_SVH
`define LOCK_MOTOR_BRIDGE_CONTROLLER_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define LMBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LMBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LMBC_ASSERT_NOW(label, ante, cons, msg)
`define LMBC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/lmbc_pkg.sv
package lmbc_pkg;

    // Bridge drive states, encoded as they appear on the result word.
    typedef enum logic [1:0] {
        MODE_OFF = 2'd0,
        MODE_FWD = 2'd1,
        MODE_REV = 2'd2
    } mode_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // Register indexes of the configuration channel.
    localparam cfg_index_t CFG_RUN_TIMEOUT       = 3'd0;
    localparam cfg_index_t CFG_LIMIT_RELOAD      = 3'd1;
    localparam cfg_index_t CFG_BLINK_PERIOD      = 3'd2;
    localparam cfg_index_t CFG_PATTERN_REVERSE   = 3'd3;
    localparam cfg_index_t CFG_PATTERN_FORWARD   = 3'd4;
    localparam cfg_index_t CFG_PATTERN_REED_OPEN = 3'd5;

    localparam int TIMEOUT_W = 15;
    localparam int COUNT_W   = 16;
    localparam int PERIOD_W  = 16;
    localparam int PATTERN_W = 8;

    // Register values after reset.
    localparam logic [TIMEOUT_W-1:0] RUN_TIMEOUT_RST       = 15'd1000;
    localparam logic [TIMEOUT_W-1:0] LIMIT_RELOAD_RST      = 15'd800;
    localparam logic [PERIOD_W-1:0]  BLINK_PERIOD_RST      = 16'd200;
    localparam logic [PATTERN_W-1:0] PATTERN_REVERSE_RST   = 8'h01;
    localparam logic [PATTERN_W-1:0] PATTERN_FORWARD_RST   = 8'h05;
    localparam logic [PATTERN_W-1:0] PATTERN_REED_OPEN_RST = 8'hE7;
    localparam logic [PATTERN_W-1:0] STARTUP_PATTERN       = 8'h15;

endpackage

FILE: hw/rtl/lmbc_channels.sv
// Tick channel: one word per timer tick with the four sampled contacts.
interface lmbc_tick_if;
    logic valid;
    logic ready;
    logic button_level;
    logic limit_a_level;
    logic limit_b_level;
    logic reed_level;

    modport source (output valid, output button_level, output limit_a_level,
                    output limit_b_level, output reed_level, input ready);
    modport sink   (input valid, input button_level, input limit_a_level,
                    input limit_b_level, input reed_level, output ready);
endinterface

// Result channel: bridge drive and LED level after each tick.
interface lmbc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] drive_mode;
    logic       led_on;

    modport source (output valid, output drive_mode, output led_on, input ready);
    modport sink   (input valid, input drive_mode, input led_on, output ready);
endinterface

// Configuration write channel.
interface lmbc_cfg_if
    import lmbc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    cfg_index_t            index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/lock_motor_bridge_controller.sv
// Lock motor H-bridge controller, one word on the tick channel per timer tick.
// Each tick word carries the sampled button, limit A, limit B and reed levels,
// all active low. The block debounces the button and both limit switches with
// shift-register histories, times the motor run, toggles the bridge on a
// stable button press and plays a short LED blink pattern.
// Every accepted tick word produces exactly one result word with the bridge
// drive (off, forward or reverse) and the LED level after that tick.
// Each tick word is taken into the input register and moves on to the result
// register, which raises result valid; while the result register is full and
// not being emptied, the word waits in the input register. Throughput is one
// tick per cycle while the receiver takes results; the single-pass update logic
// between the two registers sets it.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more tick word; only with both full does ready drop.
// Configuration words are taken at any time (ready is always high) but should
// only be written while no tick is in flight.
// Reset clears all histories, counters and flags but sets blink pending, turns
// the bridge off, loads the start-up blink pattern and restores config defaults.
module lock_motor_bridge_controller
    import lmbc_pkg::*;
#(
    parameter int BUTTON_FILTER_LEN = 16,
    parameter int LIMIT_FILTER_LEN  = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    lmbc_cfg_if.sink      cfg,
    lmbc_tick_if.sink     tick_in,
    lmbc_result_if.source result
);

`include "lock_motor_bridge_controller_macros.svh"

    // Configuration registers.
    logic [TIMEOUT_W-1:0] run_timeout_reg;
    logic [TIMEOUT_W-1:0] limit_reload_reg;
    logic [PERIOD_W-1:0]  blink_period_reg;
    logic [PATTERN_W-1:0] pattern_reverse_reg;
    logic [PATTERN_W-1:0] pattern_forward_reg;
    logic [PATTERN_W-1:0] pattern_reed_open_reg;

    // Input register holding one tick word.
    logic in_valid_reg;
    logic in_button_reg;
    logic in_limit_a_reg;
    logic in_limit_b_reg;
    logic in_reed_reg;

    // Controller state.
    logic [BUTTON_FILTER_LEN-1:0] button_history_reg, button_history_next;
    logic [LIMIT_FILTER_LEN-1:0]  limit_a_history_reg, limit_a_history_next;
    logic [LIMIT_FILTER_LEN-1:0]  limit_b_history_reg, limit_b_history_next;
    logic                         button_armed_reg, button_armed_next;
    logic                         limit_a_armed_reg, limit_a_armed_next;
    logic                         limit_b_armed_reg, limit_b_armed_next;
    mode_t                        bridge_mode_reg, bridge_mode_next;
    logic [COUNT_W-1:0]           run_count_reg, run_count_next;
    logic [PERIOD_W-1:0]          blink_ticks_reg, blink_ticks_next;
    logic [PATTERN_W-1:0]         blink_bits_reg, blink_bits_next;
    logic                         blink_pending_reg, blink_pending_next;
    logic                         led_level_reg, led_level_next;

    // Result register.
    logic       out_valid_reg;
    logic [1:0] out_mode_reg;
    logic       out_led_reg;

    // Intermediate values of the tick update.
    logic               advance;
    logic [COUNT_W-1:0] run_count_inc;
    logic               run_timed_out;
    logic [PERIOD_W-1:0] blink_ticks_inc;
    logic               blink_shift;
    logic               button_press;
    logic               limit_a_press;
    logic               limit_b_press;

    // The tick in the input register is processed once the result register
    // is empty or is being emptied in this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick_in.ready = !in_valid_reg || advance;
    assign cfg.ready     = 1'b1;

    assign result.valid      = out_valid_reg;
    assign result.drive_mode = out_mode_reg;
    assign result.led_on     = out_led_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_timeout_reg       <= RUN_TIMEOUT_RST;
            limit_reload_reg      <= LIMIT_RELOAD_RST;
            blink_period_reg      <= BLINK_PERIOD_RST;
            pattern_reverse_reg   <= PATTERN_REVERSE_RST;
            pattern_forward_reg   <= PATTERN_FORWARD_RST;
            pattern_reed_open_reg <= PATTERN_REED_OPEN_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_RUN_TIMEOUT:       run_timeout_reg       <= cfg.data[TIMEOUT_W-1:0];
                CFG_LIMIT_RELOAD:      limit_reload_reg      <= cfg.data[TIMEOUT_W-1:0];
                CFG_BLINK_PERIOD:      blink_period_reg      <= cfg.data[PERIOD_W-1:0];
                CFG_PATTERN_REVERSE:   pattern_reverse_reg   <= cfg.data[PATTERN_W-1:0];
                CFG_PATTERN_FORWARD:   pattern_forward_reg   <= cfg.data[PATTERN_W-1:0];
                CFG_PATTERN_REED_OPEN: pattern_reed_open_reg <= cfg.data[PATTERN_W-1:0];
                default:               ;
            endcase
        end
    end

    // Input register: the valid flag is reset, the sampled levels are not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick_in.ready)
        begin
            in_valid_reg <= tick_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_in.valid && tick_in.ready)
        begin
            in_button_reg  <= tick_in.button_level;
            in_limit_a_reg <= tick_in.limit_a_level;
            in_limit_b_reg <= tick_in.limit_b_level;
            in_reed_reg    <= tick_in.reed_level;
        end
    end

    // One tick of controller behavior, in the order the steps take effect.
    always_comb
    begin
        button_history_next  = {button_history_reg[BUTTON_FILTER_LEN-2:0], in_button_reg};
        limit_a_history_next = {limit_a_history_reg[LIMIT_FILTER_LEN-2:0], in_limit_a_reg};
        limit_b_history_next = {limit_b_history_reg[LIMIT_FILTER_LEN-2:0], in_limit_b_reg};

        // The run count only advances while the bridge drives, but the
        // timeout check runs in every tick, also with the bridge off.
        run_count_inc = (bridge_mode_reg != MODE_OFF) ? run_count_reg + 1'b1
                                                      : run_count_reg;
        run_timed_out = run_count_inc > {1'b0, run_timeout_reg};
        if (run_timed_out)
        begin
            bridge_mode_next = MODE_OFF;
            run_count_next   = '0;
        end
        else
        begin
            bridge_mode_next = bridge_mode_reg;
            run_count_next   = run_count_inc;
        end

        blink_ticks_inc = blink_ticks_reg + 1'b1;

        // A filter arms on an all-ones history (contact released) and fires
        // on a following all-zeros history (contact pressed).
        button_press       = (button_history_next == '0) && button_armed_reg;
        button_armed_next  = (button_armed_reg || (button_history_next == '1))
                             && !button_press;
        limit_a_press      = (limit_a_history_next == '0) && limit_a_armed_reg;
        limit_a_armed_next = (limit_a_armed_reg || (limit_a_history_next == '1))
                             && !limit_a_press;
        limit_b_press      = (limit_b_history_next == '0) && limit_b_armed_reg;
        limit_b_armed_next = (limit_b_armed_reg || (limit_b_history_next == '1))
                             && !limit_b_press;

        blink_bits_next    = blink_bits_reg;
        blink_pending_next = blink_pending_reg;
        if (button_press)
        begin
            blink_pending_next = 1'b1;
            if (in_reed_reg == 1'b0 && in_limit_a_reg == 1'b0)
            begin
                blink_bits_next = pattern_reverse_reg;
            end
            else if (in_reed_reg == 1'b0)
            begin
                blink_bits_next = pattern_forward_reg;
            end
            else
            begin
                blink_bits_next = pattern_reed_open_reg;
            end

            // A press while driving turns the bridge off; from off it drives
            // reverse only with both reed and limit A closed.
            if (bridge_mode_next != MODE_OFF)
            begin
                bridge_mode_next = MODE_OFF;
                run_count_next   = '0;
            end
            else if (in_reed_reg == 1'b0 && in_limit_a_reg == 1'b0)
            begin
                bridge_mode_next = MODE_REV;
            end
            else
            begin
                bridge_mode_next = MODE_FWD;
            end
        end

        if (limit_a_press || limit_b_press)
        begin
            run_count_next = {1'b0, limit_reload_reg};
        end

        // LED shift: an empty pattern still shifts out a zero and then
        // stops the blinking.
        blink_shift      = blink_ticks_inc > blink_period_reg;
        led_level_next   = led_level_reg;
        blink_ticks_next = blink_ticks_inc;
        if (blink_shift)
        begin
            blink_ticks_next = '0;
            if (blink_pending_next)
            begin
                if (blink_bits_next == '0)
                begin
                    blink_pending_next = 1'b0;
                end
                led_level_next  = blink_bits_next[0];
                blink_bits_next = blink_bits_next >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_history_reg  <= '0;
            limit_a_history_reg <= '0;
            limit_b_history_reg <= '0;
            button_armed_reg    <= 1'b0;
            limit_a_armed_reg   <= 1'b0;
            limit_b_armed_reg   <= 1'b0;
            bridge_mode_reg     <= MODE_OFF;
            run_count_reg       <= '0;
            blink_ticks_reg     <= '0;
            blink_bits_reg      <= STARTUP_PATTERN;
            blink_pending_reg   <= 1'b1;
            led_level_reg       <= 1'b0;
        end
        else if (advance)
        begin
            button_history_reg  <= button_history_next;
            limit_a_history_reg <= limit_a_history_next;
            limit_b_history_reg <= limit_b_history_next;
            button_armed_reg    <= button_armed_next;
            limit_a_armed_reg   <= limit_a_armed_next;
            limit_b_armed_reg   <= limit_b_armed_next;
            bridge_mode_reg     <= bridge_mode_next;
            run_count_reg       <= run_count_next;
            blink_ticks_reg     <= blink_ticks_next;
            blink_bits_reg      <= blink_bits_next;
            blink_pending_reg   <= blink_pending_next;
            led_level_reg       <= led_level_next;
        end
    end

    // Result register: loaded with the state after each processed tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_mode_reg <= bridge_mode_next;
            out_led_reg  <= led_level_next;
        end
    end

    // Ready only drops with both the input and result registers occupied.
    `LMBC_ASSERT_NOW(a_ready_low_only_full, !tick_in.ready,
        in_valid_reg && out_valid_reg && !result.ready,
        "tick channel stalled with a free register")

    // A timeout without a button press leaves the bridge off.
    `LMBC_ASSERT_NEXT(a_timeout_turns_off, advance && run_timed_out && !button_press,
        bridge_mode_reg == MODE_OFF,
        "bridge still drives after run timeout")

    // Blinking only stops once the pattern has run out.
    `LMBC_ASSERT_NOW(a_pending_clears_empty, $fell(blink_pending_reg),
        blink_bits_reg == '0,
        "blink pending cleared with pattern bits left")

    // Every LED shift restarts the blink tick counter.
    `LMBC_ASSERT_NEXT(a_shift_restarts_ticks, advance && blink_shift,
        blink_ticks_reg == '0,
        "blink tick counter not cleared after shift")

endmodule

FILE: sim/tb_lock_motor_bridge_controller.sv
module tb_lock_motor_bridge_controller
    import lmbc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // The filter lengths match the defaults of the block and are passed to it explicitly.
    localparam int BUTTON_LEN = 16;
    localparam int LIMIT_LEN = 32;

    // The block registers the tick word and then the result word; wait_until_idle
    // adds this settle time after the last result.
    localparam int SETTLE_CYCLES = 4;

    // Upper bound on the run length for the watchdog.
    localparam int CYCLE_LIMIT = 150000;

    // Idle probability in percent for both the sender and the receiver.
    localparam int IDLE_PERCENT = 35;

    // This is how long the receiver withholds ready when the long stall is requested.
    localparam int LONG_STALL_CYCLES = 80;

    typedef struct packed {
        bit button;
        bit limit_a;
        bit limit_b;
        bit reed;
    } tick_word_t;

    typedef struct {
        mode_t drive;
        bit    led;
    } drive_led_t;

    logic clk = 1'b0;
    logic rst_n;

    lmbc_cfg_if    cfg_bus ();
    lmbc_tick_if   tick_bus ();
    lmbc_result_if result_bus ();

    lock_motor_bridge_controller #(
        .BUTTON_FILTER_LEN (BUTTON_LEN),
        .LIMIT_FILTER_LEN  (LIMIT_LEN)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .tick_in (tick_bus),
        .result  (result_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Tick words that wait for the driver, and the drive/LED pairs that wait for the block.
    tick_word_t tick_queue[$];
    drive_led_t drive_led_due[$];

    int  failures = 0;
    int  cycle_count = 0;
    bit  tick_taken = 1'b0;
    bit  calm_stretch = 1'b0;
    bit  long_stall_request = 1'b0;

    // These are the register values that the predictor uses. They are updated
    // whenever a configuration word is accepted.
    logic [TIMEOUT_W-1:0] timeout_cfg;
    logic [TIMEOUT_W-1:0] reload_cfg;
    logic [PERIOD_W-1:0]  period_cfg;
    logic [PATTERN_W-1:0] reverse_cfg;
    logic [PATTERN_W-1:0] forward_cfg;
    logic [PATTERN_W-1:0] reed_open_cfg;

    // This is the predictor's own copy of the controller state.
    logic [BUTTON_LEN-1:0] button_trail;
    logic [LIMIT_LEN-1:0]  limit_a_trail;
    logic [LIMIT_LEN-1:0]  limit_b_trail;
    bit                    button_primed;
    bit                    limit_a_primed;
    bit                    limit_b_primed;
    mode_t                 bridge_now;
    logic [COUNT_W-1:0]    run_ticks;
    logic [PERIOD_W-1:0]   blink_count;
    logic [PATTERN_W-1:0]  blink_shift;
    bit                    blink_live;
    bit                    led_now;

    // This puts the predictor into the state that the block holds after reset.
    task automatic clear_prediction();
        timeout_cfg    = RUN_TIMEOUT_RST;
        reload_cfg     = LIMIT_RELOAD_RST;
        period_cfg     = BLINK_PERIOD_RST;
        reverse_cfg    = PATTERN_REVERSE_RST;
        forward_cfg    = PATTERN_FORWARD_RST;
        reed_open_cfg  = PATTERN_REED_OPEN_RST;
        button_trail   = '0;
        limit_a_trail  = '0;
        limit_b_trail  = '0;
        button_primed  = 1'b0;
        limit_a_primed = 1'b0;
        limit_b_primed = 1'b0;
        bridge_now     = MODE_OFF;
        run_ticks      = '0;
        blink_count    = '0;
        blink_shift    = STARTUP_PATTERN;
        blink_live     = 1'b1;
        led_now        = 1'b0;
    endtask

    // This advances the predictor by one timer tick and returns the bridge drive
    // and the LED level that the block must report for that tick.
    function automatic drive_led_t next_drive_and_led(tick_word_t w);
        drive_led_t r;
        mode_t      heading;
        button_trail  = {button_trail[BUTTON_LEN-2:0], w.button};
        limit_a_trail = {limit_a_trail[LIMIT_LEN-2:0], w.limit_a};
        limit_b_trail = {limit_b_trail[LIMIT_LEN-2:0], w.limit_b};

        // The run timer counts only while the bridge drives, but the timeout
        // check also runs while the bridge is off.
        if (bridge_now != MODE_OFF)
            run_ticks = run_ticks + 1'b1;
        if (run_ticks > {1'b0, timeout_cfg})
        begin
            bridge_now = MODE_OFF;
            run_ticks  = '0;
        end
        blink_count = blink_count + 1'b1;

        // A stable release arms the button. A stable press after that toggles the
        // bridge and always loads a new blink pattern, even when it turns off.
        if (button_trail == '1)
            button_primed = 1'b1;
        if (button_trail == '0 && button_primed)
        begin
            button_primed = 1'b0;
            if (!w.reed && !w.limit_a)
            begin
                blink_shift = reverse_cfg;
                heading     = MODE_REV;
            end
            else if (!w.reed)
            begin
                blink_shift = forward_cfg;
                heading     = MODE_FWD;
            end
            else
            begin
                blink_shift = reed_open_cfg;
                heading     = MODE_FWD;
            end
            blink_live = 1'b1;
            if (bridge_now != MODE_OFF)
            begin
                bridge_now = MODE_OFF;
                run_ticks  = '0;
            end
            else
                bridge_now = heading;
        end

        // A stable press of either limit switch reloads the run timer.
        if (limit_a_trail == '1)
            limit_a_primed = 1'b1;
        if (limit_a_trail == '0 && limit_a_primed)
        begin
            limit_a_primed = 1'b0;
            run_ticks      = {1'b0, reload_cfg};
        end
        if (limit_b_trail == '1)
            limit_b_primed = 1'b1;
        if (limit_b_trail == '0 && limit_b_primed)
        begin
            limit_b_primed = 1'b0;
            run_ticks      = {1'b0, reload_cfg};
        end

        // When the pattern is already empty at a shift, the blinking stops and the LED goes dark.
        if (blink_count > period_cfg)
        begin
            if (blink_live)
            begin
                if (blink_shift == '0)
                    blink_live = 1'b0;
                led_now     = blink_shift[0];
                blink_shift = blink_shift >> 1;
            end
            blink_count = '0;
        end

        r.drive = bridge_now;
        r.led   = led_now;
        return r;
    endfunction

    // This queues n tick words. The button and limit levels are held, reed is
    // random on every tick, and now and then one contact bounces. With
    // wobble_a set, limit A changes at random, which varies the direction
    // that a button press picks. With scramble set, every contact is random.
    function automatic int queue_run(int n, bit button, bit limit_a, bit limit_b,
                                     bit wobble_a, bit scramble);
        tick_word_t w;
        for (int i = 0; i < n; i++)
        begin
            w.button  = button;
            w.limit_a = wobble_a ? 1'($urandom_range(1)) : limit_a;
            w.limit_b = limit_b;
            w.reed    = 1'($urandom_range(1));
            if (scramble)
                w = 4'($urandom_range(15));
            else if ($urandom_range(199) == 0)
                w = w ^ (4'b0001 << $urandom_range(3));
            tick_queue.push_back(w);
        end
        return n;
    endfunction

    // This queues about count tick words. Most of them form well-shaped release
    // and press sequences for the button and the limit switches. The rest
    // are steady holds and plain noise.
    task automatic queue_contact_activity(input int count);
        int added;
        int pick;
        int which;
        bit level_a;
        bit level_b;
        bit level_btn;
        added = 0;
        while (added < count)
        begin
            pick    = $urandom_range(99);
            level_a = 1'($urandom_range(1));
            level_b = 1'($urandom_range(1));
            if (pick < 50)
            begin
                added += queue_run($urandom_range(16, 20), 1'b1, level_a, level_b,
                                   pick < 20, 1'b0);
                added += queue_run($urandom_range(16, 22), 1'b0, level_a, level_b,
                                   pick < 20, 1'b0);
            end
            else if (pick < 70)
            begin
                // Bit 0 selects limit A and bit 1 selects limit B. The other
                // switch that is not selected stays at a random level.
                which     = $urandom_range(1, 3);
                level_btn = 1'($urandom_range(1));
                added += queue_run($urandom_range(32, 36), level_btn,
                                   which[0] ? 1'b1 : level_a, which[1] ? 1'b1 : level_b,
                                   1'b0, 1'b0);
                added += queue_run($urandom_range(32, 38), level_btn,
                                   which[0] ? 1'b0 : level_a, which[1] ? 1'b0 : level_b,
                                   1'b0, 1'b0);
            end
            else if (pick < 85)
                added += queue_run($urandom_range(1, 30), 1'($urandom_range(1)),
                                   level_a, level_b, 1'b0, 1'b0);
            else
                added += queue_run($urandom_range(1, 20), 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        end
    endtask

    // This waits until every queued tick is accepted and every expected result has
    // arrived, and then lets the block settle.
    task automatic wait_until_idle();
        while (tick_queue.size() != 0 || tick_bus.valid || drive_led_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // This writes one register on the configuration channel. The predictor takes
    // the new value once the word has been accepted.
    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        case (idx)
            CFG_RUN_TIMEOUT:       timeout_cfg   = value[TIMEOUT_W-1:0];
            CFG_LIMIT_RELOAD:      reload_cfg    = value[TIMEOUT_W-1:0];
            CFG_BLINK_PERIOD:      period_cfg    = value[PERIOD_W-1:0];
            CFG_PATTERN_REVERSE:   reverse_cfg   = value[PATTERN_W-1:0];
            CFG_PATTERN_FORWARD:   forward_cfg   = value[PATTERN_W-1:0];
            CFG_PATTERN_REED_OPEN: reed_open_cfg = value[PATTERN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic write_all_registers(input int timeout, input int reload, input int period,
                                       input int reverse, input int forward, input int reed_open);
        write_register(CFG_RUN_TIMEOUT, 16'(timeout));
        write_register(CFG_LIMIT_RELOAD, 16'(reload));
        write_register(CFG_BLINK_PERIOD, 16'(period));
        write_register(CFG_PATTERN_REVERSE, 16'(reverse));
        write_register(CFG_PATTERN_FORWARD, 16'(forward));
        write_register(CFG_PATTERN_REED_OPEN, 16'(reed_open));
    endtask

    // The tick driver. When the last word has been accepted, or the channel is
    // empty, it either offers the next queued word or idles. A word that is
    // on offer stays stable until the block takes it.
    always @(negedge clk)
    begin
        tick_word_t w;
        if (!rst_n)
            tick_bus.valid <= 1'b0;
        else if (!tick_bus.valid || tick_taken)
        begin
            if (tick_queue.size() != 0 &&
                (calm_stretch || $urandom_range(99) >= IDLE_PERCENT))
            begin
                w = tick_queue.pop_front();
                tick_bus.valid         <= 1'b1;
                tick_bus.button_level  <= w.button;
                tick_bus.limit_a_level <= w.limit_a;
                tick_bus.limit_b_level <= w.limit_b;
                tick_bus.reed_level    <= w.reed;
            end
            else
                tick_bus.valid <= 1'b0;
        end
    end

    // The result receiver. It withholds ready at random, except during a calm
    // stretch. When a long stall is requested, it withholds ready for
    // LONG_STALL_CYCLES, which it counts itself. During that time the block fills
    // and has to stall the tick channel.
    int stall_left = 0;
    bit stall_done = 1'b0;

    always @(negedge clk)
    begin
        if (long_stall_request && !stall_done)
        begin
            stall_left = LONG_STALL_CYCLES;
            stall_done = 1'b1;
        end
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            result_bus.ready <= 1'b0;
        end
        else if (calm_stretch)
            result_bus.ready <= 1'b1;
        else
            result_bus.ready <= ($urandom_range(99) >= IDLE_PERCENT);
    end

    // The monitor. Each accepted tick word advances the predictor. Each accepted
    // result word is checked against the oldest prediction.
    always @(posedge clk)
    begin
        drive_led_t want;
        tick_word_t seen;
        tick_taken <= tick_bus.valid && tick_bus.ready;
        if (rst_n)
        begin
            if (tick_bus.valid && tick_bus.ready)
            begin
                seen.button  = tick_bus.button_level;
                seen.limit_a = tick_bus.limit_a_level;
                seen.limit_b = tick_bus.limit_b_level;
                seen.reed    = tick_bus.reed_level;
                drive_led_due.push_back(next_drive_and_led(seen));
            end
            if (result_bus.valid && result_bus.ready)
            begin
                if (drive_led_due.size() == 0)
                begin
                    $error("result word with no tick pending: drive_mode %0d led_on %0d",
                           result_bus.drive_mode, result_bus.led_on);
                    failures++;
                end
                else
                begin
                    want = drive_led_due.pop_front();
                    if (result_bus.drive_mode !== want.drive)
                    begin
                        $error("drive_mode mismatch: expected %0d, actual %0d",
                               want.drive, result_bus.drive_mode);
                        failures++;
                    end
                    if (result_bus.led_on !== want.led)
                    begin
                        $error("led_on mismatch: expected %0d, actual %0d",
                               want.led, result_bus.led_on);
                        failures++;
                    end
                end
            end
        end
    end

    // The watchdog. A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        // Every input of the block has a known value from time zero.
        rst_n                  = 1'b0;
        tick_bus.valid         = 1'b0;
        tick_bus.button_level  = 1'b1;
        tick_bus.limit_a_level = 1'b1;
        tick_bus.limit_b_level = 1'b1;
        tick_bus.reed_level    = 1'b1;
        result_bus.ready       = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = CFG_RUN_TIMEOUT;
        cfg_bus.data           = '0;
        clear_prediction();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // The directed part runs with the reset values. It drives every combination of the four
        // contacts, so each level appears on each input, both pressed and released.
        for (int c = 0; c < 16; c++)
            tick_queue.push_back(tick_word_t'(4'(c)));
        wait_until_idle();

        // Phase one: a blink period of zero, so the LED shifts on every tick. The
        // patterns are empty, full and mixed, and the run timeout is short. Neither
        // side idles for this whole phase.
        write_all_registers(40, 10, 0, 8'hFF, 8'h00, 8'hA5);
        calm_stretch = 1'b1;
        queue_contact_activity(420);
        wait_until_idle();
        calm_stretch = 1'b0;

        // Phase two: a timeout of zero and the largest reload value, so any drive
        // ends within a tick or two. Partway through, the receiver holds off
        // for a long time while ticks are still on offer.
        write_all_registers(0, 32767, 3, $urandom_range(255), $urandom_range(255),
                            $urandom_range(255));
        queue_contact_activity(420);
        while (tick_queue.size() > 300)
            @(posedge clk);
        long_stall_request = 1'b1;
        wait_until_idle();

        // Phase three: the largest timeout, a period just below the largest and a reload
        // of zero. The LED holds its level, and drives end only on a toggle. The sender stops halfway
        // until every result has come back, and then resumes.
        write_all_registers(32767, 0, 65534, $urandom_range(255), $urandom_range(255),
                            $urandom_range(255));
        queue_contact_activity(200);
        wait_until_idle();
        queue_contact_activity(200);
        wait_until_idle();

        // Phase four: moderate random settings that let timeouts, reloads
        // and blinking interact.
        write_all_registers($urandom_range(20, 150), $urandom_range(0, 100),
                            $urandom_range(0, 6), $urandom_range(255),
                            $urandom_range(255), $urandom_range(255));
        queue_contact_activity(440);
        wait_until_idle();

        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
